/* src/dlle_pkg.sv */
// Shared types and constants of the doubly linked list engine.
package dlle_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned OP_W     = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned AFF_W    = 8;

  localparam logic [OP_W-1:0] OP_INS_HEAD  = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_TAIL  = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_AFTER = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_HEAD  = 3'd3;
  localparam logic [OP_W-1:0] OP_DEL_TAIL  = 3'd4;
  localparam logic [OP_W-1:0] OP_DEL_AFTER = 3'd5;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE      = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_WAIT_D,
    S_WR_A,
    S_WR_B,
    S_RESP
  } state_e;

  typedef logic [AFF_W-1:0] node_id_t;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic signed [DATA_W-1:0] search_key;
    logic signed [DATA_W-1:0] new_value;
  } in_beat_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    node_id_t            affected_node;
  } out_beat_t;

  typedef struct packed {
    logic data;
    logic next;
    logic prev;
  } wen_t;

endpackage

/* src/dlle_node_store.sv */
// Node store: data word and both links per node, field write enables, registered read.
module dlle_node_store #(
  parameter int unsigned NODE_COUNT = 128
) (
  input  logic                             clk_i,
  input  logic                             ren_i,
  input  logic [$clog2(NODE_COUNT)-1:0]    raddr_i,
  input  dlle_pkg::wen_t                   wen_i,
  input  logic [$clog2(NODE_COUNT)-1:0]    waddr_i,
  input  logic [dlle_pkg::DATA_W-1:0]      wdata_i,
  input  logic [$clog2(NODE_COUNT):0]      wnext_i,
  input  logic [$clog2(NODE_COUNT):0]      wprev_i,
  output logic [dlle_pkg::DATA_W-1:0]      rdata_o,
  output logic [$clog2(NODE_COUNT):0]      rnext_o,
  output logic [$clog2(NODE_COUNT):0]      rprev_o
);

  localparam int unsigned IW = $clog2(NODE_COUNT);
  localparam int unsigned LW = IW + 1;

  typedef struct packed {
    logic [dlle_pkg::DATA_W-1:0] data;
    logic [LW-1:0]               next;
    logic [LW-1:0]               prev;
  } entry_t;

  entry_t mem_q [NODE_COUNT];
  entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wen_i.data) begin
      mem_q[waddr_i].data <= wdata_i;
    end
    if (wen_i.next) begin
      mem_q[waddr_i].next <= wnext_i;
    end
    if (wen_i.prev) begin
      mem_q[waddr_i].prev <= wprev_i;
    end
    if (ren_i) begin
      rd_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rd_q.data;
  assign rnext_o = rd_q.next;
  assign rprev_o = rd_q.prev;

endmodule

/* src/doubly_linked_list_engine.sv */
// Doubly linked list engine: six list operations on an array-backed node store.
//
// Input channel in_valid_i/in_ready_o carries one operation beat (operation,
// search_key, new_value). Output channel out_valid_o/out_ready_i returns one
// beat per input: status and the index of the node inserted or unlinked.
// One item is worked at a time; in_ready_o is high whenever the sequencer is
// idle, even while the previous result still sits in the output register.
// Early errors and unused codes go straight to the response step, and head
// operations need no walk; tail insert, tail delete and key searches walk the
// list from the head, since the walk does one node store read per cycle.
// The result beat becomes valid in the cycle in which in_ready_o rises again.
// Reset clears the head pointer to null and the allocation counter to zero;
// node contents are undefined until written and need no clearing pass.
// When the receiver stalls, the result stays in the output register; one
// further item is accepted and finished, then held until the register frees.
module doubly_linked_list_engine #(
  parameter int unsigned NODE_COUNT = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dlle_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dlle_pkg::out_beat_t out_data_o
);

  localparam int unsigned IW = $clog2(NODE_COUNT);
  localparam int unsigned LW = IW + 1;
  localparam logic [LW-1:0] LINK_NULL = {LW{1'b1}};
  localparam logic [LW-1:0] CNT_FULL  = LW'(NODE_COUNT);
  localparam dlle_pkg::node_id_t NONE_NODE = dlle_pkg::node_id_t'(NODE_COUNT);

  dlle_pkg::state_e             state_q, state_d;
  logic [dlle_pkg::OP_W-1:0]    op_q, op_d;
  logic [dlle_pkg::DATA_W-1:0]  key_q, key_d;
  logic [dlle_pkg::DATA_W-1:0]  val_q, val_d;
  logic [LW-1:0]                head_q, head_d;
  logic [LW-1:0]                cnt_q, cnt_d;
  logic [LW-1:0]                cur_q, cur_d;
  logic [LW-1:0]                nxt_q, nxt_d;
  logic [LW-1:0]                aux_q, aux_d;
  dlle_pkg::status_e            status_q, status_d;
  dlle_pkg::node_id_t           aff_q, aff_d;
  logic                         out_valid_q, out_valid_d;
  dlle_pkg::out_beat_t          out_data_q, out_data_d;

  logic                         mem_ren;
  logic [IW-1:0]                mem_raddr;
  dlle_pkg::wen_t               mem_wen;
  logic [IW-1:0]                mem_waddr;
  logic [dlle_pkg::DATA_W-1:0]  mem_wdata;
  logic [LW-1:0]                mem_wnext;
  logic [LW-1:0]                mem_wprev;
  logic [dlle_pkg::DATA_W-1:0]  rd_data;
  logic [LW-1:0]                rd_next;
  logic [LW-1:0]                rd_prev;

  logic full;
  logic head_null;
  logic tail_mode;
  logic rd_next_null;
  logic walk_hit;
  logic res_slot;

  dlle_node_store #(
    .NODE_COUNT (NODE_COUNT)
  ) u_store (
    .clk_i   (clk_i),
    .ren_i   (mem_ren),
    .raddr_i (mem_raddr),
    .wen_i   (mem_wen),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .wnext_i (mem_wnext),
    .wprev_i (mem_wprev),
    .rdata_o (rd_data),
    .rnext_o (rd_next),
    .rprev_o (rd_prev)
  );

  assign full         = (cnt_q == CNT_FULL);
  assign head_null    = head_q[LW-1];
  assign tail_mode    = (op_q == dlle_pkg::OP_INS_TAIL) || (op_q == dlle_pkg::OP_DEL_TAIL);
  assign rd_next_null = rd_next[LW-1];
  assign walk_hit     = tail_mode ? rd_next_null : (rd_data == key_q);
  assign res_slot     = !out_valid_q || out_ready_i;

  assign in_ready_o  = (state_q == dlle_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dlle_pkg::S_IDLE: begin
        if (in_valid_i) begin
          unique case (in_data_i.operation)
            dlle_pkg::OP_INS_HEAD:
              state_d = (full || head_null) ? dlle_pkg::S_RESP : dlle_pkg::S_WR_A;
            dlle_pkg::OP_INS_TAIL:
              state_d = (full || head_null) ? dlle_pkg::S_RESP : dlle_pkg::S_WALK;
            dlle_pkg::OP_INS_AFTER, dlle_pkg::OP_DEL_TAIL, dlle_pkg::OP_DEL_AFTER:
              state_d = head_null ? dlle_pkg::S_RESP : dlle_pkg::S_WALK;
            dlle_pkg::OP_DEL_HEAD:
              state_d = head_null ? dlle_pkg::S_RESP : dlle_pkg::S_WAIT_D;
            default:
              state_d = dlle_pkg::S_RESP;
          endcase
        end
      end
      dlle_pkg::S_WALK: begin
        if (!walk_hit) begin
          state_d = (!tail_mode && rd_next_null) ? dlle_pkg::S_RESP : dlle_pkg::S_WALK;
        end else begin
          unique case (op_q)
            dlle_pkg::OP_INS_TAIL:  state_d = dlle_pkg::S_WR_A;
            dlle_pkg::OP_INS_AFTER: state_d = full ? dlle_pkg::S_RESP : dlle_pkg::S_WR_A;
            dlle_pkg::OP_DEL_AFTER:
              state_d = rd_next_null ? dlle_pkg::S_RESP : dlle_pkg::S_WAIT_D;
            default:                state_d = dlle_pkg::S_RESP;
          endcase
        end
      end
      dlle_pkg::S_WAIT_D: begin
        state_d = (op_q == dlle_pkg::OP_DEL_AFTER && !rd_next_null) ? dlle_pkg::S_WR_B
                                                                    : dlle_pkg::S_RESP;
      end
      dlle_pkg::S_WR_A: begin
        state_d = (op_q == dlle_pkg::OP_INS_AFTER && !aux_q[LW-1]) ? dlle_pkg::S_WR_B
                                                                   : dlle_pkg::S_RESP;
      end
      dlle_pkg::S_WR_B: begin
        state_d = dlle_pkg::S_RESP;
      end
      dlle_pkg::S_RESP: begin
        state_d = res_slot ? dlle_pkg::S_IDLE : dlle_pkg::S_RESP;
      end
      default: begin
        state_d = dlle_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    op_d        = op_q;
    key_d       = key_q;
    val_d       = val_q;
    head_d      = head_q;
    cnt_d       = cnt_q;
    cur_d       = cur_q;
    nxt_d       = nxt_q;
    aux_d       = aux_q;
    status_d    = status_q;
    aff_d       = aff_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    mem_ren     = 1'b0;
    mem_raddr   = head_q[IW-1:0];
    mem_wen     = '0;
    mem_waddr   = cnt_q[IW-1:0];
    mem_wdata   = val_q;
    mem_wnext   = LINK_NULL;
    mem_wprev   = LINK_NULL;

    unique case (state_q)
      dlle_pkg::S_IDLE: begin
        if (in_valid_i) begin
          op_d     = in_data_i.operation;
          key_d    = in_data_i.search_key;
          val_d    = in_data_i.new_value;
          cur_d    = head_q;
          status_d = dlle_pkg::STAT_DONE;
          aff_d    = NONE_NODE;
          unique case (in_data_i.operation)
            dlle_pkg::OP_INS_HEAD: begin
              if (full) begin
                status_d = dlle_pkg::STAT_FULL;
              end else begin
                mem_wen   = '1;
                mem_wdata = in_data_i.new_value;
                mem_wnext = head_q;
                cnt_d     = cnt_q + 1'b1;
                head_d    = cnt_q;
                nxt_d     = cnt_q;
                aff_d     = dlle_pkg::node_id_t'(cnt_q);
              end
            end
            dlle_pkg::OP_INS_TAIL: begin
              if (full) begin
                status_d = dlle_pkg::STAT_FULL;
              end else if (head_null) begin
                mem_wen   = '1;
                mem_wdata = in_data_i.new_value;
                cnt_d     = cnt_q + 1'b1;
                head_d    = cnt_q;
                aff_d     = dlle_pkg::node_id_t'(cnt_q);
              end else begin
                mem_ren = 1'b1;
              end
            end
            dlle_pkg::OP_INS_AFTER, dlle_pkg::OP_DEL_AFTER: begin
              if (head_null) begin
                status_d = dlle_pkg::STAT_NOT_FOUND;
              end else begin
                mem_ren = 1'b1;
              end
            end
            dlle_pkg::OP_DEL_HEAD, dlle_pkg::OP_DEL_TAIL: begin
              if (head_null) begin
                status_d = dlle_pkg::STAT_EMPTY;
              end else begin
                mem_ren = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      dlle_pkg::S_WALK: begin
        if (!walk_hit) begin
          if (!tail_mode && rd_next_null) begin
            status_d = dlle_pkg::STAT_NOT_FOUND;
          end else begin
            mem_ren   = 1'b1;
            mem_raddr = rd_next[IW-1:0];
            cur_d     = rd_next;
          end
        end else begin
          unique case (op_q)
            dlle_pkg::OP_INS_TAIL: begin
              mem_wen   = '1;
              mem_wprev = cur_q;
              cnt_d     = cnt_q + 1'b1;
              nxt_d     = cnt_q;
              aff_d     = dlle_pkg::node_id_t'(cnt_q);
            end
            dlle_pkg::OP_INS_AFTER: begin
              if (full) begin
                status_d = dlle_pkg::STAT_FULL;
              end else begin
                mem_wen   = '1;
                mem_wnext = rd_next;
                mem_wprev = cur_q;
                cnt_d     = cnt_q + 1'b1;
                nxt_d     = cnt_q;
                aux_d     = rd_next;
                aff_d     = dlle_pkg::node_id_t'(cnt_q);
              end
            end
            dlle_pkg::OP_DEL_TAIL: begin
              aff_d = dlle_pkg::node_id_t'(cur_q);
              if (!rd_prev[LW-1]) begin
                mem_wen.next = 1'b1;
                mem_waddr    = rd_prev[IW-1:0];
              end else begin
                head_d = LINK_NULL;
              end
            end
            dlle_pkg::OP_DEL_AFTER: begin
              if (rd_next_null) begin
                status_d = dlle_pkg::STAT_NOT_FOUND;
              end else begin
                nxt_d     = rd_next;
                mem_ren   = 1'b1;
                mem_raddr = rd_next[IW-1:0];
              end
            end
            default: begin
            end
          endcase
        end
      end
      dlle_pkg::S_WAIT_D: begin
        if (op_q == dlle_pkg::OP_DEL_HEAD) begin
          aff_d  = dlle_pkg::node_id_t'(cur_q);
          head_d = rd_next;
          if (!rd_next_null) begin
            mem_wen.prev = 1'b1;
            mem_waddr    = rd_next[IW-1:0];
          end
        end else begin
          aff_d        = dlle_pkg::node_id_t'(nxt_q);
          aux_d        = rd_next;
          mem_wen.next = 1'b1;
          mem_waddr    = cur_q[IW-1:0];
          mem_wnext    = rd_next;
        end
      end
      dlle_pkg::S_WR_A: begin
        mem_waddr = cur_q[IW-1:0];
        if (op_q == dlle_pkg::OP_INS_HEAD) begin
          mem_wen.prev = 1'b1;
          mem_wprev    = nxt_q;
        end else begin
          mem_wen.next = 1'b1;
          mem_wnext    = nxt_q;
        end
      end
      dlle_pkg::S_WR_B: begin
        mem_wen.prev = 1'b1;
        mem_waddr    = aux_q[IW-1:0];
        mem_wprev    = (op_q == dlle_pkg::OP_DEL_AFTER) ? cur_q : nxt_q;
      end
      dlle_pkg::S_RESP: begin
        if (res_slot) begin
          out_valid_d              = 1'b1;
          out_data_d.status        = status_q;
          out_data_d.affected_node = aff_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dlle_pkg::S_IDLE;
      head_q      <= LINK_NULL;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    key_q      <= key_d;
    val_q      <= val_d;
    cur_q      <= cur_d;
    nxt_q      <= nxt_d;
    aux_q      <= aux_d;
    status_q   <= status_d;
    aff_q      <= aff_d;
    out_data_q <= out_data_d;
  end

  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_ren && (mem_wen.data || mem_wen.next || mem_wen.prev)) |-> (mem_raddr != mem_waddr))
    else $error("node store read and written at the same entry");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_FULL)
    else $error("allocation counter past store size");

  a_head_allocated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_q[LW-1] |-> (head_q < cnt_q))
    else $error("head points at an unallocated node");

  a_result_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == dlle_pkg::S_RESP))
    else $error("result beat raised outside the response step");

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// Testbench for doubly_linked_list_engine: directed rows, then random traffic vs a list model.
module tb_top;

  localparam int NODES        = 128;
  localparam int NIL          = -1;
  localparam int WATCHDOG     = 4000;
  localparam int RANDOM_ITEMS = 1228;

  localparam logic [dlle_pkg::OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [dlle_pkg::OP_W-1:0] OP_SPARE_HI = 3'd7;

  typedef logic signed [dlle_pkg::DATA_W-1:0] word_t;

  typedef struct {
    dlle_pkg::in_beat_t  beat;
    bit                  known;
    dlle_pkg::out_beat_t result;
  } row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  dlle_pkg::in_beat_t  in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  dlle_pkg::out_beat_t out_data_o;

  doubly_linked_list_engine #(
    .NODE_COUNT(NODES)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  word_t               node_val  [NODES];
  int                  node_next [NODES];
  int                  node_prev [NODES];
  int                  head_node = NIL;
  int                  alloc_cnt = 0;
  dlle_pkg::out_beat_t pending_results[$];
  row_t                rows[$];
  int                  errors      = 0;
  int                  idle_cycles = 0;
  int                  burst_left  = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int walk_tail();
    int n;
    int steps;
    n = head_node;
    steps = 0;
    while (steps < NODES && node_next[n] != NIL) begin
      n = node_next[n];
      steps++;
    end
    return n;
  endfunction

  function automatic int find_first(input word_t key);
    int n;
    int steps;
    n = head_node;
    steps = 0;
    while (n != NIL && steps < NODES) begin
      if (node_val[n] == key) return n;
      n = node_next[n];
      steps++;
    end
    return NIL;
  endfunction

  function automatic int take_node(input word_t value);
    int n;
    if (alloc_cnt >= NODES) return NIL;
    n = alloc_cnt;
    alloc_cnt++;
    node_val[n]  = value;
    node_next[n] = NIL;
    node_prev[n] = NIL;
    return n;
  endfunction

  function automatic dlle_pkg::out_beat_t list_apply(input dlle_pkg::in_beat_t b);
    int                  n;
    int                  t;
    int                  d;
    int                  after;
    int                  aff;
    bit                  empty;
    dlle_pkg::status_e   st;
    dlle_pkg::out_beat_t res;
    st = dlle_pkg::STAT_DONE;
    aff = NODES;
    empty = (head_node == NIL);
    case (b.operation)
      dlle_pkg::OP_INS_HEAD: begin
        n = take_node(b.new_value);
        if (n == NIL) begin
          st = dlle_pkg::STAT_FULL;
        end else begin
          node_next[n] = head_node;
          if (!empty) node_prev[head_node] = n;
          head_node = n;
          aff = n;
        end
      end
      dlle_pkg::OP_INS_TAIL: begin
        n = take_node(b.new_value);
        if (n == NIL) begin
          st = dlle_pkg::STAT_FULL;
        end else begin
          if (empty) begin
            head_node = n;
          end else begin
            t = walk_tail();
            node_next[t] = n;
            node_prev[n] = t;
          end
          aff = n;
        end
      end
      dlle_pkg::OP_INS_AFTER: begin
        t = find_first(b.search_key);
        if (t == NIL) begin
          st = dlle_pkg::STAT_NOT_FOUND;
        end else if (alloc_cnt >= NODES) begin
          st = dlle_pkg::STAT_FULL;
        end else begin
          n = take_node(b.new_value);
          after = node_next[t];
          node_next[n] = after;
          node_prev[n] = t;
          if (after != NIL) node_prev[after] = n;
          node_next[t] = n;
          aff = n;
        end
      end
      dlle_pkg::OP_DEL_HEAD: begin
        if (empty) begin
          st = dlle_pkg::STAT_EMPTY;
        end else begin
          aff = head_node;
          head_node = node_next[head_node];
          if (head_node != NIL) node_prev[head_node] = NIL;
        end
      end
      dlle_pkg::OP_DEL_TAIL: begin
        if (empty) begin
          st = dlle_pkg::STAT_EMPTY;
        end else begin
          t = walk_tail();
          aff = t;
          if (node_prev[t] != NIL) node_next[node_prev[t]] = NIL;
          else head_node = NIL;
        end
      end
      dlle_pkg::OP_DEL_AFTER: begin
        t = find_first(b.search_key);
        if (t == NIL || node_next[t] == NIL) begin
          st = dlle_pkg::STAT_NOT_FOUND;
        end else begin
          d = node_next[t];
          after = node_next[d];
          node_next[t] = after;
          if (after != NIL) node_prev[after] = t;
          aff = d;
        end
      end
      default: ;
    endcase
    res.status = st;
    res.affected_node = dlle_pkg::node_id_t'(aff);
    return res;
  endfunction

  function automatic word_t live_value();
    int n;
    int len;
    int k;
    len = 0;
    n = head_node;
    while (n != NIL && len < NODES) begin
      len++;
      n = node_next[n];
    end
    k = $urandom_range(0, len - 1);
    n = head_node;
    repeat (k) n = node_next[n];
    return node_val[n];
  endfunction

  function automatic word_t draw_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return word_t'($urandom_range(0, 6)) - 3;
    if (r < 85) return word_t'($urandom);
    case ($urandom_range(0, 3))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  function automatic word_t draw_key();
    if (head_node != NIL && $urandom_range(0, 99) < 70) return live_value();
    return draw_value();
  endfunction

  function automatic logic [dlle_pkg::OP_W-1:0] draw_op(input bit grow);
    int r;
    r = $urandom_range(0, 99);
    if (grow) begin
      if (r < 22) return dlle_pkg::OP_INS_HEAD;
      if (r < 44) return dlle_pkg::OP_INS_TAIL;
      if (r < 66) return dlle_pkg::OP_INS_AFTER;
      if (r < 74) return dlle_pkg::OP_DEL_HEAD;
      if (r < 82) return dlle_pkg::OP_DEL_TAIL;
      if (r < 95) return dlle_pkg::OP_DEL_AFTER;
    end else begin
      if (r < 10) return dlle_pkg::OP_INS_HEAD;
      if (r < 20) return dlle_pkg::OP_INS_TAIL;
      if (r < 30) return dlle_pkg::OP_INS_AFTER;
      if (r < 50) return dlle_pkg::OP_DEL_HEAD;
      if (r < 70) return dlle_pkg::OP_DEL_TAIL;
      if (r < 95) return dlle_pkg::OP_DEL_AFTER;
    end
    return ($urandom_range(0, 1) != 0) ? OP_SPARE_LO : OP_SPARE_HI;
  endfunction

  task automatic add_row(input logic [dlle_pkg::OP_W-1:0] op, input word_t key,
                         input word_t value, input bit known, input dlle_pkg::status_e st,
                         input int node);
    row_t r;
    r.beat.operation = op;
    r.beat.search_key = key;
    r.beat.new_value = value;
    r.known = known;
    r.result.status = st;
    r.result.affected_node = dlle_pkg::node_id_t'(node);
    rows.push_back(r);
  endtask

  task automatic issue(input row_t r);
    int                  gap;
    dlle_pkg::out_beat_t res;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_data_i <= r.beat;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    res = list_apply(r.beat);
    pending_results.push_back(r.known ? r.result : res);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // receiver stall pattern
  initial begin
    int          span;
    logic [15:0] pat;
    out_ready_i = 1'b0;
    forever begin
      pat = ($urandom_range(0, 3) == 0) ? 16'hffff : (16'($urandom) | 16'h0001);
      span = $urandom_range(32, 200);
      for (int i = 0; i < span; i++) begin
        out_ready_i <= pat[i % 16];
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    dlle_pkg::out_beat_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: result with none expected, status %0d node %0d", $time,
                   out_data_o.status, out_data_o.affected_node);
        end else begin
          want = pending_results.pop_front();
          if (want.status != out_data_o.status) begin
            errors++;
            $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                     want.status, out_data_o.status);
          end
          if (want.affected_node != out_data_o.affected_node) begin
            errors++;
            $display("%0t: affected_node mismatch, expected %0d, actual %0d", $time,
                     want.affected_node, out_data_o.affected_node);
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("%0t: watchdog expired", $time);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    row_t r;
    int   count;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    add_row(dlle_pkg::OP_DEL_HEAD,  32'sd0,        32'sd0,        1,
            dlle_pkg::STAT_EMPTY,     NODES);
    add_row(dlle_pkg::OP_DEL_TAIL,  32'sd0,        32'sd0,        1,
            dlle_pkg::STAT_EMPTY,     NODES);
    add_row(dlle_pkg::OP_DEL_AFTER, 32'sd0,        32'sd0,        1,
            dlle_pkg::STAT_NOT_FOUND, NODES);
    add_row(dlle_pkg::OP_INS_AFTER, 32'sd0,        32'sd0,        1,
            dlle_pkg::STAT_NOT_FOUND, NODES);
    add_row(OP_SPARE_LO,            32'sd0,        32'sd0,        1,
            dlle_pkg::STAT_DONE,      NODES);
    add_row(OP_SPARE_HI,            '1,            '1,            1,
            dlle_pkg::STAT_DONE,      NODES);
    add_row(dlle_pkg::OP_INS_HEAD,  '1,            32'sh7fffffff, 1,
            dlle_pkg::STAT_DONE,      0);
    add_row(dlle_pkg::OP_INS_TAIL,  32'sh7fffffff, 32'sh80000000, 1,
            dlle_pkg::STAT_DONE,      1);
    add_row(dlle_pkg::OP_INS_AFTER, 32'sh7fffffff, 32'sd0,        1,
            dlle_pkg::STAT_DONE,      2);
    add_row(dlle_pkg::OP_INS_HEAD,  32'sd0,        '1,            1,
            dlle_pkg::STAT_DONE,      3);
    add_row(dlle_pkg::OP_DEL_AFTER, 32'sh80000000, 32'sd0,        1,
            dlle_pkg::STAT_NOT_FOUND, NODES);
    add_row(dlle_pkg::OP_DEL_AFTER, 32'sd12345,    32'sd0,        1,
            dlle_pkg::STAT_NOT_FOUND, NODES);
    add_row(dlle_pkg::OP_DEL_AFTER, 32'sh7fffffff, 32'sd0,        1,
            dlle_pkg::STAT_DONE,      2);
    add_row(dlle_pkg::OP_INS_AFTER, 32'sh80000000, 32'sh5555aaaa, 1,
            dlle_pkg::STAT_DONE,      4);
    add_row(dlle_pkg::OP_DEL_TAIL,  32'sd0,        32'sd0,        1,
            dlle_pkg::STAT_DONE,      4);
    add_row(dlle_pkg::OP_DEL_HEAD,  32'sd0,        32'sd0,        1,
            dlle_pkg::STAT_DONE,      3);
    add_row(dlle_pkg::OP_INS_HEAD,  32'sd0,        32'sd5,        0,
            dlle_pkg::STAT_DONE,      0);
    add_row(dlle_pkg::OP_INS_TAIL,  32'sd0,        32'sd5,        0,
            dlle_pkg::STAT_DONE,      0);
    add_row(dlle_pkg::OP_INS_AFTER, 32'sd5,        32'shaaaa5555, 0,
            dlle_pkg::STAT_DONE,      0);
    add_row(dlle_pkg::OP_DEL_AFTER, 32'sd5,        32'sd0,        0,
            dlle_pkg::STAT_DONE,      0);
    add_row(dlle_pkg::OP_DEL_TAIL,  32'sd0,        32'sd0,        0,
            dlle_pkg::STAT_DONE,      0);
    add_row(dlle_pkg::OP_DEL_TAIL,  32'sd0,        32'sd0,        0,
            dlle_pkg::STAT_DONE,      0);
    add_row(dlle_pkg::OP_DEL_HEAD,  32'sd0,        32'sd0,        0,
            dlle_pkg::STAT_DONE,      0);
    add_row(dlle_pkg::OP_DEL_HEAD,  32'sd0,        32'sd0,        0,
            dlle_pkg::STAT_DONE,      0);
    add_row(dlle_pkg::OP_DEL_TAIL,  32'sd0,        32'sd0,        1,
            dlle_pkg::STAT_EMPTY,     NODES);

    foreach (rows[i]) issue(rows[i]);
    drain_results();

    count = 0;
    while (count < RANDOM_ITEMS) begin
      r.beat.operation = draw_op(alloc_cnt < NODES);
      r.beat.search_key = draw_key();
      r.beat.new_value = draw_value();
      r.known = 0;
      r.result = '0;
      issue(r);
      count++;
      if (count == RANDOM_ITEMS / 2) drain_results();
    end

    drain_results();
    repeat (NODES + 16) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
